// ===== hw/rtl/fbse_pkg.sv =====
// fbse_pkg: shared types and constants of the fermion basis state engine
// used by fbse_step, fermion_basis_state_engine_core and its testbench
// no dependencies
package fbse_pkg;

  localparam int MAX_ORBITALS_DEF = 32;

  localparam int MODE_W    = 4;
  localparam int SITE_W    = 5;
  localparam int VALUE_W   = 3;
  localparam int BITS_W    = 32;
  localparam int NUM_ORB_W = 6;
  localparam int TOTAL_W   = 7;

  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 72;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [NUM_ORB_W-1:0] NUM_ORB_RESET = NUM_ORB_W'(32);
  localparam logic [TOTAL_W-1:0]   TOTAL_RESET   = TOTAL_W'(32);

  // register index as decoded from the word address
  typedef enum logic {
    REG_NUM_ORBITALS = 1'b0,
    REG_TOTAL        = 1'b1
  } fbse_reg_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_INIT    = 4'd0,
    MODE_NEXT    = 4'd1,
    MODE_N_UP    = 4'd2,
    MODE_N_DN    = 4'd3,
    MODE_N       = 4'd4,
    MODE_N_UD    = 4'd5,
    MODE_CDAG_UP = 4'd6,
    MODE_CDAG_DN = 4'd7,
    MODE_C_UP    = 4'd8,
    MODE_C_DN    = 4'd9,
    MODE_HOP_UP  = 4'd10,
    MODE_HOP_DN  = 4'd11
  } fbse_mode_t;

  typedef logic signed [VALUE_W-1:0] fbse_value_t;

  localparam fbse_value_t VAL_ZERO      = 3'sb000;
  localparam fbse_value_t VAL_ONE       = 3'sb001;
  localparam fbse_value_t VAL_TWO       = 3'sb010;
  localparam fbse_value_t VAL_MINUS_ONE = 3'sb111;

  typedef struct packed {
    logic [NUM_ORB_W-1:0] num_orbitals;
    logic [TOTAL_W-1:0]   total_particles;
  } fbse_cfg_t;

endpackage

// ===== hw/rtl/fbse_advance.sv =====
// fbse_advance: steps one occupation string to the next larger value with equal popcount
// wraps to the lowest pattern at the top, holds a full or empty string; depends on nothing but its parameters
// instantiated by fbse_step
module fbse_advance #(
  parameter int W  = 32,
  parameter int CW = 6
) (
  input  logic [W-1:0]  x,
  input  logic [CW-1:0] norb,
  output logic [CW-1:0] ones,
  output logic          advanced,
  output logic [W-1:0]  next_x
);

  localparam int IW = (W > 1) ? $clog2(W) : 1;

  logic [W-1:0]  top;
  logic [W-1:0]  low;
  logic [W-1:0]  lsb;
  logic [W-1:0]  sum;
  logic [W-1:0]  spread;
  logic [IW-1:0] tz;
  logic          idle;
  logic          wrap;

  always_comb begin
    ones = '0;
    for (int b = 0; b < W; b++) begin
      ones = ones + CW'(x[b]);
    end
    idle = (ones == norb) || (ones == '0);
    // highest pattern: the top popcount bits inside the orbital range
    for (int b = 0; b < W; b++) begin
      top[b] = (b < int'(norb)) && (b >= int'(norb) - int'(ones));
      low[b] = (b < int'(ones));
    end
    lsb = x & (~x + W'(1));
    tz  = '0;
    for (int b = W - 1; b >= 0; b--) begin
      if (x[b]) begin
        tz = IW'(b);
      end
    end
    sum    = x + lsb;
    // division by the lowest set bit is a right shift by its position
    spread = (((sum ^ x) >> 2) >> tz) | sum;
    wrap   = (x >= top);
    advanced = !idle && !wrap;
    if (idle) begin
      next_x = x;
    end else if (wrap) begin
      next_x = low;
    end else begin
      next_x = spread;
    end
  end

endmodule

// ===== hw/rtl/fbse_step.sv =====
// fbse_step: combinational next state and value for one request
// depends on fbse_pkg and fbse_advance
module fbse_step #(
  parameter int W  = fbse_pkg::MAX_ORBITALS_DEF,
  parameter int CW = $clog2(fbse_pkg::MAX_ORBITALS_DEF + 1)
) (
  input  logic [fbse_pkg::MODE_W-1:0] mode,
  input  logic [fbse_pkg::SITE_W-1:0] site,
  input  logic [fbse_pkg::SITE_W-1:0] target_site,
  input  fbse_pkg::fbse_cfg_t         cfg,
  input  logic [W-1:0]                up_q,
  input  logic [W-1:0]                dn_q,
  input  logic [CW-1:0]               up_cnt_q,
  input  logic [CW-1:0]               dn_cnt_q,
  output fbse_pkg::fbse_value_t       value,
  output logic [W-1:0]                up_d,
  output logic [W-1:0]                dn_d,
  output logic [CW-1:0]               up_cnt_d,
  output logic [CW-1:0]               dn_cnt_d
);

  localparam int TW = CW + 1;

  logic [CW-1:0] norb;
  logic [TW-1:0] two_n;
  logic [TW-1:0] tot;
  logic [CW-1:0] dn0;
  logic [CW-1:0] up0;
  logic [CW-1:0] up_mv;
  logic [CW-1:0] dn_mv;
  logic [CW-1:0] nu;
  logic [CW-1:0] nd;
  logic [W-1:0]  mask_norb;
  logic [W-1:0]  um;
  logic [W-1:0]  dm;
  logic [W-1:0]  eq_i;
  logic [W-1:0]  eq_j;
  logic [W-1:0]  above_i;
  logic [W-1:0]  above_j;
  logic [W-1:0]  u_next;
  logic [W-1:0]  d_next;
  logic          u_adv;
  logic          d_adv;
  logic          iok;
  logic          jok;
  logic          ui;
  logic          di;
  logic          uj;
  logic          dj;
  logic          pu_i;
  logic          pd_i;
  logic          pu_j;
  logic          pd_j;
  logic          pu_all;
  logic          i_gt_j;

  function automatic logic [W-1:0] low_bits(input int k);
    logic [W-1:0] r;
    for (int b = 0; b < W; b++) begin
      r[b] = (b < k);
    end
    return r;
  endfunction

  function automatic fbse_pkg::fbse_value_t sgn(input logic neg);
    return neg ? fbse_pkg::VAL_MINUS_ONE : fbse_pkg::VAL_ONE;
  endfunction

  always_comb begin
    norb = (int'(cfg.num_orbitals) > W) ? CW'(W) : CW'(cfg.num_orbitals);
    two_n = {norb, 1'b0};
    tot = (int'(cfg.total_particles) > int'(two_n)) ? two_n : TW'(cfg.total_particles);
    dn0 = (tot > {1'b0, norb}) ? norb : CW'(tot);
    up0 = CW'(tot - {1'b0, dn0});
    up_mv = (int'(up_cnt_q) < W) ? up_cnt_q + CW'(1) : up_cnt_q;
    dn_mv = (dn_cnt_q != '0) ? dn_cnt_q - CW'(1) : dn_cnt_q;
    mask_norb = low_bits(int'(norb));
    um = up_q & mask_norb;
    dm = dn_q & mask_norb;
    for (int b = 0; b < W; b++) begin
      eq_i[b]    = (b == int'(site));
      eq_j[b]    = (b == int'(target_site));
      above_i[b] = (b > int'(site));
      above_j[b] = (b > int'(target_site));
    end
    iok    = int'(site) < int'(norb);
    jok    = int'(target_site) < int'(norb);
    ui     = |(um & eq_i);
    di     = |(dm & eq_i);
    uj     = |(um & eq_j);
    dj     = |(dm & eq_j);
    pu_i   = ^(um & above_i);
    pd_i   = ^(dm & above_i);
    pu_j   = ^(um & above_j);
    pd_j   = ^(dm & above_j);
    pu_all = ^um;
    i_gt_j = site > target_site;
  end

  fbse_advance #(.W(W), .CW(CW)) u_adv_up (
    .x        (um),
    .norb     (norb),
    .ones     (nu),
    .advanced (u_adv),
    .next_x   (u_next)
  );

  fbse_advance #(.W(W), .CW(CW)) u_adv_dn (
    .x        (dm),
    .norb     (norb),
    .ones     (nd),
    .advanced (d_adv),
    .next_x   (d_next)
  );

  always_comb begin
    value    = fbse_pkg::VAL_ZERO;
    up_d     = um;
    dn_d     = dm;
    up_cnt_d = up_cnt_q;
    dn_cnt_d = dn_cnt_q;
    case (mode)
      fbse_pkg::MODE_INIT: begin
        up_cnt_d = up0;
        dn_cnt_d = dn0;
        up_d     = low_bits(int'(up0)) & mask_norb;
        dn_d     = low_bits(int'(dn0)) & mask_norb;
      end
      fbse_pkg::MODE_NEXT: begin
        if (d_adv) begin
          dn_d  = d_next;
          value = fbse_pkg::VAL_ONE;
        end else if (u_adv) begin
          // down string has wrapped to its lowest pattern, or is held when full or empty
          dn_d  = d_next;
          up_d  = u_next;
          value = fbse_pkg::VAL_ONE;
        end else if ((TW'(nu) < tot) && (nu < norb) && (nd != '0)) begin
          up_cnt_d = up_mv;
          dn_cnt_d = dn_mv;
          up_d     = low_bits(int'(up_mv)) & mask_norb;
          dn_d     = low_bits(int'(dn_mv)) & mask_norb;
          value    = fbse_pkg::VAL_ONE;
        end else begin
          up_cnt_d = up0;
          dn_cnt_d = dn0;
          up_d     = low_bits(int'(up0)) & mask_norb;
          dn_d     = low_bits(int'(dn0)) & mask_norb;
        end
      end
      fbse_pkg::MODE_N_UP: begin
        if (iok && ui) value = fbse_pkg::VAL_ONE;
      end
      fbse_pkg::MODE_N_DN: begin
        if (iok && di) value = fbse_pkg::VAL_ONE;
      end
      fbse_pkg::MODE_N: begin
        if (iok) begin
          if (ui && di) begin
            value = fbse_pkg::VAL_TWO;
          end else if (ui || di) begin
            value = fbse_pkg::VAL_ONE;
          end
        end
      end
      fbse_pkg::MODE_N_UD: begin
        if (iok && ui && di) value = fbse_pkg::VAL_ONE;
      end
      fbse_pkg::MODE_CDAG_UP: begin
        if (iok && !ui) begin
          up_d  = um | eq_i;
          value = sgn(pu_i);
        end
      end
      fbse_pkg::MODE_CDAG_DN: begin
        if (iok && !di) begin
          dn_d  = dm | eq_i;
          value = sgn(pd_i ^ pu_all);
        end
      end
      fbse_pkg::MODE_C_UP: begin
        if (iok && ui) begin
          up_d  = um & ~eq_i;
          value = sgn(pu_i);
        end
      end
      fbse_pkg::MODE_C_DN: begin
        if (iok && di) begin
          dn_d  = dm & ~eq_i;
          value = sgn(pd_i ^ pu_all);
        end
      end
      fbse_pkg::MODE_HOP_UP: begin
        if (iok && jok && ui) begin
          // target still occupied after removal: annihilation stays, value zero
          if (uj && (site != target_site)) begin
            up_d = um & ~eq_i;
          end else begin
            up_d  = (um & ~eq_i) | eq_j;
            value = sgn(pu_i ^ pu_j ^ i_gt_j);
          end
        end
      end
      fbse_pkg::MODE_HOP_DN: begin
        if (iok && jok && di) begin
          // the up-string parity enters twice and cancels
          if (dj && (site != target_site)) begin
            dn_d = dm & ~eq_i;
          end else begin
            dn_d  = (dm & ~eq_i) | eq_j;
            value = sgn(pd_i ^ pd_j ^ i_gt_j);
          end
        end
      end
      default: begin
        value = fbse_pkg::VAL_ZERO;
      end
    endcase
  end

endmodule

// ===== hw/rtl/fermion_basis_state_engine_core.sv =====
// fermion_basis_state_engine_core: top level of the fermion basis state engine
// depends on fbse_pkg and fbse_step (which holds fbse_advance)
//
//  channel | direction | handshake           | payload
//  in_     | slave     | tvalid/tready       | mode, site, target_site
//  out_    | master    | tvalid/tready       | value, up_bits, down_bits
//  cfg_    | apb slave | psel/penable/pready | num_orbitals @0x0, total_particles @0x4
//
// one request per cycle while the result side is not stalled; the input
// register and the result register lie around the single step unit
// state updates when a request leaves the input register for the result register
// a stalled result holds both registers; the input side keeps taking requests
// while the input register is empty or moving
// rst_n is synchronous: strings and sector counts clear, registers load 32 and 32
module fermion_basis_state_engine_core #(
  parameter int MAX_ORBITALS = fbse_pkg::MAX_ORBITALS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [3:0] mode, [8:4] site, [13:9] target_site, [15:14] zero
  input  logic [fbse_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [2:0] value, [34:3] up_bits, [66:35] down_bits, [71:67] zero
  output logic [fbse_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [fbse_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [fbse_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [fbse_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                            cfg_pready
);

  localparam int W       = MAX_ORBITALS;
  localparam int CW      = $clog2(MAX_ORBITALS + 1);
  localparam int OUT_PAD = fbse_pkg::OUT_DATA_W - fbse_pkg::VALUE_W - 2 * fbse_pkg::BITS_W;

  fbse_pkg::fbse_cfg_t cfg_r;
  fbse_pkg::fbse_cfg_t cfg_nxt;
  fbse_pkg::fbse_reg_t cfg_sel;
  logic                cfg_wr;

  logic                        s1_valid_r;
  logic [fbse_pkg::MODE_W-1:0] s1_mode_r;
  logic [fbse_pkg::SITE_W-1:0] s1_site_r;
  logic [fbse_pkg::SITE_W-1:0] s1_target_r;
  logic                        s1_go;
  logic                        in_fire;

  logic [W-1:0]  up_r;
  logic [W-1:0]  dn_r;
  logic [CW-1:0] up_cnt_r;
  logic [CW-1:0] dn_cnt_r;
  logic [W-1:0]  up_nxt;
  logic [W-1:0]  dn_nxt;
  logic [CW-1:0] up_cnt_nxt;
  logic [CW-1:0] dn_cnt_nxt;

  fbse_pkg::fbse_value_t         value_nxt;
  logic                          out_valid_r;
  fbse_pkg::fbse_value_t         out_value_r;
  logic [fbse_pkg::BITS_W-1:0]   out_up_r;
  logic [fbse_pkg::BITS_W-1:0]   out_dn_r;

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_sel    = fbse_pkg::fbse_reg_t'(cfg_paddr[2]);

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      case (cfg_sel)
        fbse_pkg::REG_NUM_ORBITALS:
          cfg_nxt.num_orbitals = cfg_pwdata[fbse_pkg::NUM_ORB_W-1:0];
        fbse_pkg::REG_TOTAL:
          cfg_nxt.total_particles = cfg_pwdata[fbse_pkg::TOTAL_W-1:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      fbse_pkg::REG_NUM_ORBITALS: cfg_prdata = fbse_pkg::CFG_DATA_W'(cfg_r.num_orbitals);
      fbse_pkg::REG_TOTAL:        cfg_prdata = fbse_pkg::CFG_DATA_W'(cfg_r.total_particles);
      default:                    cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.num_orbitals    <= fbse_pkg::NUM_ORB_RESET;
      cfg_r.total_particles <= fbse_pkg::TOTAL_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // input register and result register handshakes
  assign s1_go     = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || s1_go;
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_mode_r   <= in_tdata[3:0];
      s1_site_r   <= in_tdata[8:4];
      s1_target_r <= in_tdata[13:9];
    end
  end

  fbse_step #(.W(W), .CW(CW)) u_step (
    .mode        (s1_mode_r),
    .site        (s1_site_r),
    .target_site (s1_target_r),
    .cfg         (cfg_r),
    .up_q        (up_r),
    .dn_q        (dn_r),
    .up_cnt_q    (up_cnt_r),
    .dn_cnt_q    (dn_cnt_r),
    .value       (value_nxt),
    .up_d        (up_nxt),
    .dn_d        (dn_nxt),
    .up_cnt_d    (up_cnt_nxt),
    .dn_cnt_d    (dn_cnt_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      up_r     <= '0;
      dn_r     <= '0;
      up_cnt_r <= '0;
      dn_cnt_r <= '0;
    end else if (s1_valid_r && s1_go) begin
      up_r     <= up_nxt;
      dn_r     <= dn_nxt;
      up_cnt_r <= up_cnt_nxt;
      dn_cnt_r <= dn_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r && s1_go) begin
      out_value_r <= value_nxt;
      out_up_r    <= fbse_pkg::BITS_W'(up_nxt);
      out_dn_r    <= fbse_pkg::BITS_W'(dn_nxt);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{OUT_PAD{1'b0}}, out_dn_r, out_up_r, out_value_r};

  // a request taken from the input lands in the input register
  a_in_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> s1_valid_r)
    else $error("accepted request missing from input register");

  // the shown strings always match the state they leave behind
  a_out_state: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_go) |=>
      (out_up_r == fbse_pkg::BITS_W'(up_r)) && (out_dn_r == fbse_pkg::BITS_W'(dn_r)))
    else $error("result strings differ from state");

  // init always reports zero
  a_init_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_go && (s1_mode_r == fbse_pkg::MODE_INIT)) |=>
      (out_value_r == fbse_pkg::VAL_ZERO))
    else $error("init produced nonzero value");

  // a count of two only comes from the total number operator
  a_two_only_n: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_go && (s1_mode_r != fbse_pkg::MODE_N)) |=>
      (out_value_r != fbse_pkg::VAL_TWO))
    else $error("value two outside number mode");

endmodule

// ===== sim/fermion_basis_state_engine_core_tb.sv =====
// fermion_basis_state_engine_core_tb: self-checking testbench of the basis state engine core
// predicts every result in its own model of the strings, sector counts and signs
// depends on fbse_pkg and fermion_basis_state_engine_core
module fermion_basis_state_engine_core_tb;

  localparam int MODE_W     = fbse_pkg::MODE_W;
  localparam int SITE_W     = fbse_pkg::SITE_W;
  localparam int VALUE_W    = fbse_pkg::VALUE_W;
  localparam int BITS_W     = fbse_pkg::BITS_W;
  localparam int NUM_ORB_W  = fbse_pkg::NUM_ORB_W;
  localparam int TOTAL_W    = fbse_pkg::TOTAL_W;
  localparam int IN_DATA_W  = fbse_pkg::IN_DATA_W;
  localparam int OUT_DATA_W = fbse_pkg::OUT_DATA_W;
  localparam int CFG_ADDR_W = fbse_pkg::CFG_ADDR_W;
  localparam int CFG_DATA_W = fbse_pkg::CFG_DATA_W;

  localparam int MAX_ORB     = fbse_pkg::MAX_ORBITALS_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [MODE_W-1:0] MODE_UNUSED_FIRST =
    MODE_W'(fbse_pkg::MODE_HOP_DN) + MODE_W'(1);
  localparam logic [MODE_W-1:0] MODE_UNUSED_LAST  = '1;

  typedef struct packed {
    fbse_pkg::fbse_value_t value;
    logic [BITS_W-1:0]     up_bits;
    logic [BITS_W-1:0]     down_bits;
  } basis_state_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  // predicted engine state
  logic [63:0]          up_str;
  logic [63:0]          dn_str;
  int                   up_cnt;
  int                   dn_cnt;
  logic [NUM_ORB_W-1:0] orb_reg;
  logic [TOTAL_W-1:0]   tot_reg;

  basis_state_t pending_states[$];
  int           mismatch_count = 0;
  int           cycle_count = 0;
  int           in_idle_pct = 0;
  int           out_stall_pct = 0;
  int           out_hold_left = 0;

  fermion_basis_state_engine_core #(
    .MAX_ORBITALS(MAX_ORB)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic int bit_count(logic [63:0] x);
    int c = 0;
    for (int k = 0; k < 64; k++) c += int'(x[k]);
    return c;
  endfunction

  function automatic logic [63:0] ones_below(int k);
    return (k >= 64) ? '1 : ((64'd1 << k) - 64'd1);
  endfunction

  function automatic int active_orbitals();
    return (int'(orb_reg) > MAX_ORB) ? MAX_ORB : int'(orb_reg);
  endfunction

  function automatic int active_total(int norb);
    return (int'(tot_reg) > 2 * norb) ? 2 * norb : int'(tot_reg);
  endfunction

  function automatic void load_lowest(int norb);
    up_str = ones_below((up_cnt < norb) ? up_cnt : norb);
    dn_str = ones_below((dn_cnt < norb) ? dn_cnt : norb);
  endfunction

  function automatic void start_sector(int norb);
    int t;
    t = active_total(norb);
    dn_cnt = (t > norb) ? norb : t;
    up_cnt = t - dn_cnt;
  endfunction

  // next larger value with the same popcount; -1 when it wraps to the lowest, 0 when full or empty
  function automatic int advance_string(inout logic [63:0] s, input int norb);
    logic [63:0] top;
    logic [63:0] c;
    logic [63:0] r;
    int          n;
    n = bit_count(s);
    if (n == norb || n == 0) return 0;
    top = ones_below(norb) & ~ones_below(norb - n);
    if (s >= top) begin
      s = ones_below(n);
      return -1;
    end
    c = s & (~s + 64'd1);
    r = s + c;
    s = (((r ^ s) >> 2) / c) | r;
    return 1;
  endfunction

  function automatic int step_next(int norb);
    int nu;
    int nd;
    if (advance_string(dn_str, norb) > 0) return 1;
    if (advance_string(up_str, norb) > 0) return 1;
    nu = bit_count(up_str);
    nd = bit_count(dn_str);
    if (nu < active_total(norb) && nu < norb && nd > 0) begin
      if (up_cnt < MAX_ORB) up_cnt++;
      if (dn_cnt > 0) dn_cnt--;
      load_lowest(norb);
      return 1;
    end
    start_sector(norb);
    load_lowest(norb);
    return 0;
  endfunction

  function automatic int parity_sign(logic [63:0] s, int i, int norb);
    return bit_count(s & ones_below(norb) & ~ones_below(i + 1)) % 2 ? -1 : 1;
  endfunction

  // down operators also pick up the parity of the whole up string
  function automatic int create_particle(bit dn, int i, int norb);
    logic [63:0] s;
    int          sg;
    s = dn ? dn_str : up_str;
    if (s[i]) return 0;
    sg = parity_sign(s, i, norb);
    if (dn && bit_count(up_str) % 2 == 1) sg = -sg;
    s[i] = 1'b1;
    if (dn) dn_str = s;
    else up_str = s;
    return sg;
  endfunction

  function automatic int remove_particle(bit dn, int i, int norb);
    logic [63:0] s;
    int          sg;
    s = dn ? dn_str : up_str;
    if (!s[i]) return 0;
    s[i] = 1'b0;
    if (dn) dn_str = s;
    else up_str = s;
    sg = parity_sign(s, i, norb);
    if (dn && bit_count(up_str) % 2 == 1) sg = -sg;
    return sg;
  endfunction

  function automatic void compute_basis_step(logic [MODE_W-1:0] mode, logic [SITE_W-1:0] i,
                                             logic [SITE_W-1:0] j);
    int           norb;
    int           v;
    int           a;
    bit           iok;
    bit           jok;
    basis_state_t r;
    norb = active_orbitals();
    iok  = int'(i) < norb;
    jok  = int'(j) < norb;
    v    = 0;
    up_str &= ones_below(norb);
    dn_str &= ones_below(norb);
    case (mode)
      fbse_pkg::MODE_INIT: begin
        start_sector(norb);
        load_lowest(norb);
      end
      fbse_pkg::MODE_NEXT: v = step_next(norb);
      fbse_pkg::MODE_N_UP: if (iok) v = int'(up_str[i]);
      fbse_pkg::MODE_N_DN: if (iok) v = int'(dn_str[i]);
      fbse_pkg::MODE_N:    if (iok) v = int'(up_str[i]) + int'(dn_str[i]);
      fbse_pkg::MODE_N_UD: if (iok) v = int'(up_str[i] & dn_str[i]);
      fbse_pkg::MODE_CDAG_UP, fbse_pkg::MODE_CDAG_DN: begin
        if (iok) v = create_particle(mode == fbse_pkg::MODE_CDAG_DN, i, norb);
      end
      fbse_pkg::MODE_C_UP, fbse_pkg::MODE_C_DN: begin
        if (iok) v = remove_particle(mode == fbse_pkg::MODE_C_DN, i, norb);
      end
      fbse_pkg::MODE_HOP_UP, fbse_pkg::MODE_HOP_DN: begin
        // a failed create leaves the annihilation in place
        if (iok && jok) begin
          a = remove_particle(mode == fbse_pkg::MODE_HOP_DN, i, norb);
          if (a != 0) v = a * create_particle(mode == fbse_pkg::MODE_HOP_DN, j, norb);
        end
      end
      default: ;
    endcase
    r.value     = VALUE_W'(v);
    r.up_bits   = up_str[BITS_W-1:0];
    r.down_bits = dn_str[BITS_W-1:0];
    pending_states.push_back(r);
  endfunction

  function automatic void compare_basis_state(logic [OUT_DATA_W-1:0] data);
    basis_state_t          want;
    fbse_pkg::fbse_value_t got_value;
    logic [BITS_W-1:0]     got_up;
    logic [BITS_W-1:0]     got_dn;
    got_value = data[VALUE_W-1:0];
    got_up    = data[VALUE_W +: BITS_W];
    got_dn    = data[VALUE_W + BITS_W +: BITS_W];
    if (pending_states.size() == 0) begin
      $display("%0t: result with no request pending, expected none, got %h", $time, data);
      mismatch_count++;
      return;
    end
    want = pending_states.pop_front();
    if (got_value !== want.value) begin
      $display("%0t: value expected %0d got %0d", $time, want.value, got_value);
      mismatch_count++;
    end
    if (got_up !== want.up_bits) begin
      $display("%0t: up_bits expected %h got %h", $time, want.up_bits, got_up);
      mismatch_count++;
    end
    if (got_dn !== want.down_bits) begin
      $display("%0t: down_bits expected %h got %h", $time, want.down_bits, got_dn);
      mismatch_count++;
    end
    if (data[OUT_DATA_W-1:VALUE_W + 2 * BITS_W] !== '0) begin
      $display("%0t: tdata padding expected 0 got %h", $time,
               data[OUT_DATA_W-1:VALUE_W + 2 * BITS_W]);
      mismatch_count++;
    end
  endfunction

  // result side: check on handshake, then pick the next ready level
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) compare_basis_state(out_tdata);
    if (out_hold_left > 0) begin
      out_tready    <= 1'b0;
      out_hold_left <= out_hold_left - 1;
    end else begin
      out_tready <= ($urandom_range(99, 0) >= out_stall_pct);
    end
  end

  task automatic send_request(logic [MODE_W-1:0] mode, logic [SITE_W-1:0] site,
                              logic [SITE_W-1:0] tgt);
    while ($urandom_range(99, 0) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, tgt, site, mode};
    do @(posedge clk); while (!in_tready);
    compute_basis_step(mode, site, tgt);
  endtask

  // many next sweeps and mostly in-range sites so that sector moves and wraps are reached
  task automatic send_random_request();
    logic [MODE_W-1:0] mode;
    logic [SITE_W-1:0] site;
    logic [SITE_W-1:0] tgt;
    int                pick;
    int                norb;
    norb = active_orbitals();
    pick = $urandom_range(99, 0);
    if (pick < 5) mode = fbse_pkg::MODE_INIT;
    else if (pick < 42) mode = fbse_pkg::MODE_NEXT;
    else if (pick < 45) mode = MODE_W'($urandom_range(MODE_UNUSED_LAST, MODE_UNUSED_FIRST));
    else mode = MODE_W'($urandom_range(int'(fbse_pkg::MODE_HOP_DN),
                                       int'(fbse_pkg::MODE_N_UP)));
    site = SITE_W'($urandom());
    tgt  = SITE_W'($urandom());
    if (norb > 0 && $urandom_range(99, 0) < 85) site = SITE_W'($urandom_range(norb - 1, 0));
    if (norb > 0 && $urandom_range(99, 0) < 85) tgt = SITE_W'($urandom_range(norb - 1, 0));
    send_request(mode, site, tgt);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_states.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(fbse_pkg::fbse_reg_t idx, logic [CFG_DATA_W-1:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (idx == fbse_pkg::REG_NUM_ORBITALS) orb_reg = data[NUM_ORB_W-1:0];
    else tot_reg = data[TOTAL_W-1:0];
  endtask

  // unused upper write bits carry random values
  task automatic set_config(int norb, int total);
    wait_idle();
    write_register(fbse_pkg::REG_NUM_ORBITALS, ($urandom() << NUM_ORB_W) | NUM_ORB_W'(norb));
    write_register(fbse_pkg::REG_TOTAL, ($urandom() << TOTAL_W) | TOTAL_W'(total));
  endtask

  task automatic set_random_config();
    int pick;
    int norb;
    int lim;
    pick = $urandom_range(99, 0);
    if (pick < 70) norb = $urandom_range(6, 1);
    else if (pick < 85) norb = $urandom_range(63, 0);
    else norb = MAX_ORB;
    lim = (2 * norb + 2 > 127) ? 127 : 2 * norb + 2;
    set_config(norb, $urandom_range(lim, 0));
  endtask

  task automatic test_directed_defaults();
    send_request(fbse_pkg::MODE_INIT, 0, 0);
    send_request(fbse_pkg::MODE_N_UP, 0, 0);
    send_request(fbse_pkg::MODE_N_DN, 31, 0);
    send_request(fbse_pkg::MODE_N, 31, 0);
    send_request(fbse_pkg::MODE_N_UD, 31, 0);
    send_request(fbse_pkg::MODE_NEXT, 0, 0);
    send_request(fbse_pkg::MODE_NEXT, 0, 0);
    send_request(fbse_pkg::MODE_CDAG_UP, 31, 0);
    send_request(fbse_pkg::MODE_CDAG_DN, 0, 0);
    send_request(fbse_pkg::MODE_C_UP, 0, 0);
    send_request(fbse_pkg::MODE_C_DN, 31, 0);
    send_request(fbse_pkg::MODE_HOP_UP, 31, 0);
    send_request(fbse_pkg::MODE_HOP_DN, 5, 31);
    send_request(MODE_UNUSED_LAST, 31, 31);
  endtask

  task automatic test_directed_small();
    set_config(5, 4);
    send_request(fbse_pkg::MODE_INIT, 0, 0);
    // target already occupied: create fails, annihilation stays
    send_request(fbse_pkg::MODE_HOP_DN, 0, 1);
    // source empty
    send_request(fbse_pkg::MODE_HOP_UP, 2, 3);
    send_request(fbse_pkg::MODE_N_UP, 7, 0);
    send_request(fbse_pkg::MODE_CDAG_UP, 31, 0);
    send_request(fbse_pkg::MODE_CDAG_UP, 0, 0);
    send_request(fbse_pkg::MODE_HOP_UP, 0, 9);
    send_request(fbse_pkg::MODE_NEXT, 0, 0);
    send_request(fbse_pkg::MODE_NEXT, 0, 0);
    send_request(MODE_UNUSED_FIRST, 0, 0);
  endtask

  task automatic test_config_extremes();
    int orbs[10]   = '{1, 1, 1, 0, 63, 32, 32, 2, 33, 3};
    int totals[10] = '{0, 1, 2, 7, 127, 64, 0, 3, 65, 3};
    for (int k = 0; k < 10; k++) begin
      set_config(orbs[k], totals[k]);
      send_request(fbse_pkg::MODE_INIT, 0, 0);
      repeat (24) send_random_request();
    end
  endtask

  task automatic run_idle_phase(int n_items, int in_pct, int out_pct);
    in_idle_pct = in_pct;
    out_stall_pct <= out_pct;
    for (int k = 0; k < n_items; k++) begin
      if (k % 60 == 0) set_random_config();
      send_random_request();
    end
  endtask

  task automatic test_idle_phases();
    run_idle_phase(180, 0, 0);
    run_idle_phase(180, 56, 0);
    run_idle_phase(180, 0, 56);
    run_idle_phase(180, 11, 11);
  endtask

  // receiver holds off while requests keep coming, so the input side backs up
  task automatic test_output_backpressure();
    set_config(4, 4);
    in_idle_pct = 0;
    out_stall_pct <= 0;
    out_hold_left <= 300;
    send_request(fbse_pkg::MODE_INIT, 0, 0);
    repeat (40) send_random_request();
  endtask

  initial begin
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    up_str  = '0;
    dn_str  = '0;
    up_cnt  = 0;
    dn_cnt  = 0;
    orb_reg = fbse_pkg::NUM_ORB_RESET;
    tot_reg = fbse_pkg::TOTAL_RESET;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_defaults();
    test_directed_small();
    test_config_extremes();
    test_idle_phases();
    test_output_backpressure();

    in_tvalid <= 1'b0;
    while (pending_states.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && pending_states.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
